// ----- src/vrrb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrrb_pkg
// Shared types and codes for the variable-length record ring buffer.
// ----------------------------------------------------------------------------
package vrrb_pkg;

	// ring size register and ring pointers
	localparam int unsigned RING_W = 13;
	localparam logic [RING_W-1:0] MIN_RING = 13'd16;

	// command codes
	typedef enum logic [1:0] {
		CMD_PUSH_BEGIN = 2'd0,
		CMD_PUSH_BYTE  = 2'd1,
		CMD_POP        = 2'd2,
		CMD_GET        = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_OVERFLOW     = 3'd1,
		ST_UNDERFLOW    = 3'd2,
		ST_NO_MAP       = 3'd3,
		ST_BAD_HANDLE   = 3'd4,
		ST_OUT_OF_SEQ   = 3'd5
	} status_t;

	// configuration register indexes
	localparam logic REG_RING_BYTES = 1'b0;
	localparam logic REG_MAP_ENABLE = 1'b1;

	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] record_length;
		logic [7:0]  data_byte;
		logic [5:0]  max_bytes;
		logic [3:0]  max_records;
		logic [31:0] handle;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] handle_out;
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        record_end;
		logic        run_last;
		logic [11:0] new_head;
		logic [5:0]  bytes_done;
	} out_t;

	// configuration as seen by the controller
	typedef struct packed {
		logic [RING_W-1:0] ring_bytes;
		logic              map_enable;
		logic              clear;
	} cfg_t;

	// controller status toward the top level
	typedef struct packed {
		logic busy;
		logic emit;
	} ctl_stat_t;

endpackage
`default_nettype wire

// ----- src/vrrb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vrrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/vrrb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrrb_ctrl
// Command sequencer: ring and handle-map memories, pointers, result staging.
// ----------------------------------------------------------------------------
module vrrb_ctrl #(
	parameter int unsigned BUF_BYTES = 4096,
	parameter int unsigned HDR_BYTES = 8,
	parameter int unsigned MAP_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire vrrb_pkg::cfg_t    cfg,
	input  wire logic              in_take,
	input  wire vrrb_pkg::in_t     in_item,
	input  wire logic              can_emit,
	output      vrrb_pkg::ctl_stat_t stat,
	output      vrrb_pkg::out_t    res
);

	localparam int unsigned RW = vrrb_pkg::RING_W;
	localparam int unsigned AW = $clog2(BUF_BYTES);
	localparam int unsigned MW = $clog2(MAP_DEPTH);
	localparam int unsigned KW = $clog2(HDR_BYTES);
	localparam logic [RW:0] HDRC = (RW+1)'(HDR_BYTES);
	localparam logic [MW:0] MAPD = (MW+1)'(MAP_DEPTH);
	localparam logic [5:0] BUDGET_MAX = 6'd56;
	localparam logic [3:0] RECS_MAX = 4'd8;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DISP  = 16'h0002,
		S_HDRW  = 16'h0004,
		S_ONE   = 16'h0008,
		S_PTEST = 16'h0010,
		S_H0    = 16'h0020,
		S_H1    = 16'h0040,
		S_H2    = 16'h0080,
		S_DRD   = 16'h0100,
		S_DEMIT = 16'h0200,
		S_PZERO = 16'h0400,
		S_PADV  = 16'h0800,
		S_PDONE = 16'h1000,
		S_GMAP  = 16'h2000,
		S_GZERO = 16'h4000,
		S_FIN   = 16'h8000
	} state_t;

	// modular helpers
	function automatic logic [RW-1:0] ring_wrap(input logic [RW:0] s, input logic [RW-1:0] r);
		logic [RW:0] rr;
		rr = {1'b0, r};
		return (s >= rr) ? RW'(s - rr) : s[RW-1:0];
	endfunction

	function automatic logic [MW-1:0] map_wrap(input logic [MW:0] s);
		return (s >= MAPD) ? MW'(s - MAPD) : s[MW-1:0];
	endfunction

	state_t            state_q;
	vrrb_pkg::in_t     in_q;
	logic [5:0]        mb_q;
	logic [3:0]        mr_q;
	logic [RW-1:0]     head_q, tail_q, wptr_q, hp_q, rptr_q, nh_q;
	logic              full_q;
	logic [31:0]       next_q, oldest_q, hout_q;
	logic [MW-1:0]     first_q;
	logic [MW:0]       count_q;
	logic [11:0]       left_q;
	logic              open_q;
	logic [7:0]        lo_q;
	logic [11:0]       len_q;
	logic [5:0]        cnt_q, i_q, done_q;
	logic [3:0]        recs_q;
	logic [KW-1:0]     k_q;
	vrrb_pkg::status_t st_q;
	logic              any_q;
	vrrb_pkg::out_t    pend_q;
	logic              pend_v_q;

	logic [RW-1:0]     ring;
	logic [RW-1:0]     used;
	logic [RW:0]       need;
	logic              no_space;
	logic [RW-1:0]     tail_nx;
	logic [MW-1:0]     map_wr_idx, map_rd_idx;
	logic [31:0]       idx;
	logic              bad;
	logic [7:0]        ring_rdata;
	logic [RW-1:0]     map_rdata;
	logic [11:0]       hl;
	logic              brk;
	logic [5:0]        get_cnt;
	logic              last_i;
	logic              is_pop;
	logic              ok_prod;
	logic              prod;
	vrrb_pkg::out_t    prod_r;
	logic              fin_emit;
	logic              ring_we, ring_re, map_we, map_re;
	logic [RW-1:0]     ring_wa, ring_ra;
	logic [7:0]        ring_wd;
	logic [7:0]        hdr_byte;

	assign ring = cfg.ring_bytes;
	assign is_pop = (in_q.cmd == vrrb_pkg::CMD_POP);
	assign ok_prod = !pend_v_q || can_emit;

	// fill level of the ring
	always_comb begin
		if (head_q == tail_q) begin
			used = full_q ? ring : '0;
		end else if (tail_q > head_q) begin
			used = tail_q - head_q;
		end else begin
			used = RW'(({1'b0, tail_q} + {1'b0, ring}) - {1'b0, head_q});
		end
	end

	// push_begin space check and new tail
	assign need = {1'b0, in_q.record_length} + HDRC;
	assign no_space = (({1'b0, used} + need) > {1'b0, ring}) ||
	                  (cfg.map_enable && (count_q >= MAPD));
	assign tail_nx = ring_wrap({1'b0, tail_q} + need, ring);
	assign map_wr_idx = map_wrap({1'b0, first_q} + count_q);

	// handle lookup
	assign idx = in_q.handle - oldest_q;
	assign bad = idx >= 32'(count_q);
	assign map_rd_idx = map_wrap({1'b0, first_q} + idx[MW:0]);

	// header decode and record checks
	assign hl = {ring_rdata[3:0], lo_q};
	assign brk = (hl > {6'b0, mb_q - done_q}) || (({1'b0, hl} + HDRC) > {1'b0, used});
	assign get_cnt = (hl < {6'b0, mb_q}) ? hl[5:0] : mb_q;
	assign last_i = ((i_q + 6'd1) == cnt_q);

	always_comb begin
		if (k_q == KW'(0)) begin
			hdr_byte = len_q[7:0];
		end else if (k_q == KW'(1)) begin
			hdr_byte = {4'b0, len_q[11:8]};
		end else begin
			hdr_byte = 8'd0;
		end
	end

	// memory requests and result production
	always_comb begin
		ring_we = 1'b0;
		ring_wa = wptr_q;
		ring_wd = hdr_byte;
		ring_re = 1'b0;
		ring_ra = hp_q;
		map_we = 1'b0;
		map_re = 1'b0;
		prod = 1'b0;
		prod_r = '0;
		prod_r.status = vrrb_pkg::ST_OK;
		prod_r.new_head = head_q[11:0];
		fin_emit = 1'b0;
		unique case (state_q)
			S_DISP: begin
				case (in_q.cmd)
					vrrb_pkg::CMD_PUSH_BEGIN: begin
						map_we = !open_q && !no_space && cfg.map_enable;
					end
					vrrb_pkg::CMD_PUSH_BYTE: begin
						ring_we = open_q;
						ring_wd = in_q.data_byte;
					end
					vrrb_pkg::CMD_GET: begin
						map_re = cfg.map_enable && !open_q && !bad;
					end
					default: ;
				endcase
			end
			S_HDRW: ring_we = 1'b1;
			S_H0: ring_re = 1'b1;
			S_H1: begin
				ring_re = 1'b1;
				ring_ra = ring_wrap({1'b0, hp_q} + 14'd1, ring);
			end
			S_DRD: begin
				ring_re = 1'b1;
				ring_ra = rptr_q;
			end
			S_ONE: begin
				prod = ok_prod;
				prod_r.status = st_q;
				prod_r.handle_out = hout_q;
			end
			S_DEMIT: begin
				prod = ok_prod;
				prod_r.out_byte = ring_rdata;
				prod_r.byte_valid = 1'b1;
				prod_r.record_end = last_i && ({6'b0, cnt_q} == len_q);
				prod_r.new_head = (is_pop && last_i) ? nh_q[11:0] : head_q[11:0];
				prod_r.bytes_done = done_q + 6'd1;
			end
			S_PZERO: begin
				prod = ok_prod;
				prod_r.record_end = 1'b1;
				prod_r.new_head = nh_q[11:0];
				prod_r.bytes_done = done_q;
			end
			S_GZERO: begin
				prod = ok_prod;
				prod_r.record_end = (len_q == 12'd0);
			end
			S_PDONE: prod = !any_q && ok_prod;
			S_FIN: fin_emit = can_emit;
			default: ;
		endcase
	end

	// result staging: one result is held back until it is known whether it is last
	always_comb begin
		res = pend_q;
		res.run_last = fin_emit;
	end
	assign stat.emit = (prod && pend_v_q) || fin_emit;
	assign stat.busy = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_q <= '0;
			mb_q <= '0;
			mr_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			wptr_q <= '0;
			hp_q <= '0;
			rptr_q <= '0;
			nh_q <= '0;
			full_q <= 1'b0;
			next_q <= '0;
			oldest_q <= '0;
			hout_q <= '0;
			first_q <= '0;
			count_q <= '0;
			left_q <= '0;
			open_q <= 1'b0;
			lo_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			i_q <= '0;
			done_q <= '0;
			recs_q <= '0;
			k_q <= '0;
			st_q <= vrrb_pkg::ST_OK;
			any_q <= 1'b0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (prod) begin
				pend_q <= prod_r;
				pend_v_q <= 1'b1;
				any_q <= 1'b1;
			end
			if (fin_emit) begin
				pend_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						in_q <= in_item;
						mb_q <= (in_item.max_bytes > BUDGET_MAX) ? BUDGET_MAX : in_item.max_bytes;
						mr_q <= (in_item.max_records > RECS_MAX) ? RECS_MAX : in_item.max_records;
						done_q <= '0;
						any_q <= 1'b0;
						hout_q <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_ONE;
					case (in_q.cmd)
						vrrb_pkg::CMD_PUSH_BEGIN: begin
							if (open_q) begin
								st_q <= vrrb_pkg::ST_OUT_OF_SEQ;
							end else if (no_space) begin
								st_q <= vrrb_pkg::ST_OVERFLOW;
							end else begin
								st_q <= vrrb_pkg::ST_OK;
								if (cfg.map_enable) begin
									hout_q <= next_q;
									if (count_q == '0) begin
										oldest_q <= next_q;
									end
									count_q <= count_q + 1'b1;
									next_q <= next_q + 32'd1;
								end
								wptr_q <= tail_q;
								tail_q <= tail_nx;
								full_q <= (tail_nx == head_q);
								len_q <= in_q.record_length;
								left_q <= in_q.record_length;
								open_q <= (in_q.record_length != 12'd0);
								k_q <= '0;
								state_q <= S_HDRW;
							end
						end
						vrrb_pkg::CMD_PUSH_BYTE: begin
							if (!open_q) begin
								st_q <= vrrb_pkg::ST_OUT_OF_SEQ;
							end else begin
								st_q <= vrrb_pkg::ST_OK;
								wptr_q <= ring_wrap({1'b0, wptr_q} + 14'd1, ring);
								left_q <= left_q - 12'd1;
								if (left_q == 12'd1) begin
									open_q <= 1'b0;
								end
							end
						end
						vrrb_pkg::CMD_POP: begin
							if (open_q) begin
								st_q <= vrrb_pkg::ST_OUT_OF_SEQ;
							end else if (used == '0) begin
								st_q <= vrrb_pkg::ST_UNDERFLOW;
							end else begin
								recs_q <= '0;
								state_q <= S_PTEST;
							end
						end
						vrrb_pkg::CMD_GET: begin
							if (!cfg.map_enable) begin
								st_q <= vrrb_pkg::ST_NO_MAP;
							end else if (open_q) begin
								st_q <= vrrb_pkg::ST_OUT_OF_SEQ;
							end else if (bad) begin
								st_q <= vrrb_pkg::ST_BAD_HANDLE;
							end else begin
								state_q <= S_GMAP;
							end
						end
						default: ;
					endcase
				end
				S_HDRW: begin
					wptr_q <= ring_wrap({1'b0, wptr_q} + 14'd1, ring);
					k_q <= k_q + 1'b1;
					if (k_q == KW'(HDR_BYTES - 1)) begin
						state_q <= S_ONE;
					end
				end
				S_ONE: begin
					if (ok_prod) begin
						state_q <= S_FIN;
					end
				end
				S_PTEST: begin
					if ((recs_q < mr_q) && (used != '0)) begin
						hp_q <= head_q;
						state_q <= S_H0;
					end else begin
						state_q <= S_PDONE;
					end
				end
				S_GMAP: begin
					hp_q <= map_rdata;
					state_q <= S_H0;
				end
				S_H0: state_q <= S_H1;
				S_H1: begin
					lo_q <= ring_rdata;
					state_q <= S_H2;
				end
				S_H2: begin
					len_q <= hl;
					i_q <= '0;
					rptr_q <= ring_wrap({1'b0, hp_q} + HDRC, ring);
					if (is_pop) begin
						nh_q <= ring_wrap({1'b0, head_q} + HDRC + {2'b0, hl}, ring);
						cnt_q <= hl[5:0];
						if (brk) begin
							state_q <= S_PDONE;
						end else if (hl == 12'd0) begin
							state_q <= S_PZERO;
						end else begin
							state_q <= S_DRD;
						end
					end else begin
						cnt_q <= get_cnt;
						state_q <= (get_cnt == 6'd0) ? S_GZERO : S_DRD;
					end
				end
				S_DRD: state_q <= S_DEMIT;
				S_DEMIT: begin
					if (ok_prod) begin
						done_q <= done_q + 6'd1;
						i_q <= i_q + 6'd1;
						rptr_q <= ring_wrap({1'b0, rptr_q} + 14'd1, ring);
						if (!last_i) begin
							state_q <= S_DRD;
						end else begin
							state_q <= is_pop ? S_PADV : S_FIN;
						end
					end
				end
				S_PZERO: begin
					if (ok_prod) begin
						state_q <= S_PADV;
					end
				end
				S_PADV: begin
					head_q <= nh_q;
					full_q <= 1'b0;
					if (cfg.map_enable && (count_q != '0)) begin
						first_q <= (first_q == MW'(MAP_DEPTH - 1)) ? '0 : first_q + 1'b1;
						count_q <= count_q - 1'b1;
						oldest_q <= oldest_q + 32'd1;
					end
					recs_q <= recs_q + 4'd1;
					state_q <= S_PTEST;
				end
				S_PDONE: begin
					if (any_q || ok_prod) begin
						state_q <= S_FIN;
					end
				end
				S_GZERO: begin
					if (ok_prod) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// register write empties the ring and the map
			if (cfg.clear) begin
				head_q <= '0;
				tail_q <= '0;
				full_q <= 1'b0;
				first_q <= '0;
				count_q <= '0;
				oldest_q <= next_q;
				left_q <= '0;
				open_q <= 1'b0;
			end
		end
	end

	// byte ring
	vrrb_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(AW'(ring_wa)),
		.wdata(ring_wd),
		.re   (ring_re),
		.raddr(AW'(ring_ra)),
		.rdata(ring_rdata)
	);

	// handle to header offset map
	vrrb_ram #(
		.WIDTH(RW),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_wr_idx),
		.wdata(tail_q),
		.re   (map_re),
		.raddr(map_rd_idx),
		.rdata(map_rdata)
	);

endmodule
`default_nettype wire

// ----- src/variable_record_ring_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// variable_record_ring_buffer
// Byte ring of length-prefixed records with handle lookup.
// ----------------------------------------------------------------------------
// One command is worked at a time; the input stalls until its last result has
// been handed to the output register. The ring memory has a single registered
// read port, which sets the pace: push_begin writes its header one byte per
// cycle, and pop and get read each record header and then read and deliver
// its data bytes one at a time. A result waiting in the output register does
// not stop the next command from being taken.
module variable_record_ring_buffer #(
	parameter int unsigned BUF_BYTES = 4096,
	parameter int unsigned HDR_BYTES = 8,
	parameter int unsigned MAP_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire vrrb_pkg::in_t                 in_data,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      vrrb_pkg::out_t                out_data,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [vrrb_pkg::RING_W-1:0]   cfg_wdata
);

	localparam int unsigned RW = vrrb_pkg::RING_W;
	localparam logic [RW-1:0] RESET_RING = RW'((BUF_BYTES < 4096) ? BUF_BYTES : 4096);

	logic [RW-1:0]       ring_q;
	logic                map_en_q;
	vrrb_pkg::cfg_t      cfg;
	vrrb_pkg::ctl_stat_t stat;
	vrrb_pkg::out_t      res;
	logic                out_valid_q;
	vrrb_pkg::out_t      out_q;
	logic                can_emit;
	logic                in_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RESET_RING;
			map_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vrrb_pkg::REG_RING_BYTES: begin
					if (cfg_wdata < vrrb_pkg::MIN_RING) begin
						ring_q <= vrrb_pkg::MIN_RING;
					end else if (32'(cfg_wdata) > BUF_BYTES) begin
						ring_q <= RW'(BUF_BYTES);
					end else begin
						ring_q <= cfg_wdata;
					end
				end
				vrrb_pkg::REG_MAP_ENABLE: map_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg.ring_bytes = ring_q;
	assign cfg.map_enable = map_en_q;
	assign cfg.clear = cfg_we;

	// input transfer
	assign in_stall = stat.busy;
	assign in_take = in_valid && !stat.busy;

	vrrb_ctrl #(
		.BUF_BYTES(BUF_BYTES),
		.HDR_BYTES(HDR_BYTES),
		.MAP_DEPTH(MAP_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_take (in_take),
		.in_item (in_data),
		.can_emit(can_emit),
		.stat    (stat),
		.res     (res)
	);

	// output register
	assign can_emit = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else if (stat.emit) begin
			out_valid_q <= 1'b1;
			out_q <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// a taken command keeps the sequencer busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> stat.busy)
		else $error("sequencer idle after command transfer");

	// results only go into a free output register
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a waiting transfer");

	// the last result of a command frees the input
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.emit && res.run_last) |=> !stat.busy)
		else $error("sequencer still busy after last result");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop and get commands into the record ring through a table of
// directed rows and then random record traffic, predicts every result in a
// local model of the ring and handle map, and compares transfers field by
// field under several sender and receiver idling phases and ring sizes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BUF = 4096;
	localparam int HDR = 8;
	localparam int MAPD = 256;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	vrrb_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vrrb_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [vrrb_pkg::RING_W-1:0] cfg_wdata = '0;

	variable_record_ring_buffer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state
	logic [7:0]  ring_mem [BUF];
	logic [11:0] map_off [MAPD];
	int unsigned ring_size, map_on;
	int unsigned head, tail, full;
	logic [31:0] next_h, oldest_h;
	int unsigned map_first, map_count, push_left, push_open;

	vrrb_pkg::out_t expected_results [$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0, recv_idle = 0;

	function automatic int unsigned ring_used();
		if (head == tail) return full ? ring_size : 0;
		if (tail > head) return tail - head;
		return tail + ring_size - head;
	endfunction

	function automatic int unsigned hdr_length(int unsigned pos);
		return {ring_mem[(pos + 1) % ring_size], ring_mem[pos % ring_size]} & 12'hFFF;
	endfunction

	function automatic void clear_ring();
		head = 0; tail = 0; full = 0;
		map_first = 0; map_count = 0; oldest_h = next_h;
		push_left = 0; push_open = 0;
	endfunction

	function automatic void add_result(vrrb_pkg::status_t st, logic [31:0] h,
			logic [7:0] b, logic v, logic e, int unsigned nh, int unsigned done);
		vrrb_pkg::out_t r;
		r.status = st; r.handle_out = h; r.out_byte = b; r.byte_valid = v;
		r.record_end = e; r.run_last = 1'b0; r.new_head = nh[11:0];
		r.bytes_done = done[5:0];
		expected_results.push_back(r);
	endfunction

	// expected results for one accepted command
	function automatic void predict_ring(vrrb_pkg::in_t c);
		int n0;
		int unsigned len, need, mb, mr, done, recs, oh, nh, idx, off, cnt;
		logic [31:0] h;
		n0 = expected_results.size();
		mb = c.max_bytes > 56 ? 56 : c.max_bytes;
		mr = c.max_records > 8 ? 8 : c.max_records;
		case (c.cmd)
			vrrb_pkg::CMD_PUSH_BEGIN: begin
				len = c.record_length; need = len + HDR; h = '0;
				if (push_open) add_result(vrrb_pkg::ST_OUT_OF_SEQ, 0, 0, 0, 0, head, 0);
				else if (ring_used() + need > ring_size || (map_on && map_count >= MAPD))
					add_result(vrrb_pkg::ST_OVERFLOW, 0, 0, 0, 0, head, 0);
				else begin
					if (map_on) begin
						h = next_h;
						if (map_count == 0) oldest_h = h;
						map_off[(map_first + map_count) % MAPD] = tail[11:0];
						map_count++;
						next_h = next_h + 1;
					end
					for (int i = 0; i < HDR; i++)
						ring_mem[(tail + i) % ring_size] =
							i == 0 ? len[7:0] : i == 1 ? len[15:8] : 8'd0;
					tail = (tail + need) % ring_size;
					full = tail == head;
					push_left = len; push_open = len != 0;
					add_result(vrrb_pkg::ST_OK, h, 0, 0, 0, head, 0);
				end
			end
			vrrb_pkg::CMD_PUSH_BYTE: begin
				if (!push_open) add_result(vrrb_pkg::ST_OUT_OF_SEQ, 0, 0, 0, 0, head, 0);
				else begin
					ring_mem[(tail + ring_size - push_left) % ring_size] = c.data_byte;
					push_left--;
					if (push_left == 0) push_open = 0;
					add_result(vrrb_pkg::ST_OK, 0, 0, 0, 0, head, 0);
				end
			end
			vrrb_pkg::CMD_POP: begin
				done = 0; recs = 0;
				if (push_open) add_result(vrrb_pkg::ST_OUT_OF_SEQ, 0, 0, 0, 0, head, 0);
				else if (ring_used() == 0)
					add_result(vrrb_pkg::ST_UNDERFLOW, 0, 0, 0, 0, head, 0);
				else begin
					while (recs < mr && ring_used() > 0) begin
						len = hdr_length(head); oh = head;
						if (len > mb - done || len + HDR > ring_used()) break;
						nh = (head + HDR + len) % ring_size;
						for (int unsigned i = 0; i < len; i++) begin
							done++;
							add_result(vrrb_pkg::ST_OK, 0,
								ring_mem[(oh + HDR + i) % ring_size], 1,
								i + 1 == len, i + 1 == len ? nh : oh, done);
						end
						if (len == 0) add_result(vrrb_pkg::ST_OK, 0, 0, 0, 1, nh, done);
						head = nh; full = 0;
						if (map_on && map_count) begin
							map_first = (map_first + 1) % MAPD;
							map_count--;
							oldest_h = oldest_h + 1;
						end
						recs++;
					end
					if (expected_results.size() == n0)
						add_result(vrrb_pkg::ST_OK, 0, 0, 0, 0, head, 0);
				end
			end
			default: begin
				idx = c.handle - oldest_h;
				if (!map_on) add_result(vrrb_pkg::ST_NO_MAP, 0, 0, 0, 0, head, 0);
				else if (push_open)
					add_result(vrrb_pkg::ST_OUT_OF_SEQ, 0, 0, 0, 0, head, 0);
				else if (idx >= map_count)
					add_result(vrrb_pkg::ST_BAD_HANDLE, 0, 0, 0, 0, head, 0);
				else begin
					off = map_off[(map_first + idx) % MAPD];
					len = hdr_length(off); cnt = len < mb ? len : mb;
					for (int unsigned i = 0; i < cnt; i++)
						add_result(vrrb_pkg::ST_OK, 0, ring_mem[(off + HDR + i) % ring_size],
							1, i + 1 == cnt && cnt == len, head, i + 1);
					if (cnt == 0) add_result(vrrb_pkg::ST_OK, 0, 0, 0, len == 0, head, 0);
				end
			end
		endcase
		expected_results[$].run_last = 1'b1;
	endfunction

	// result checking
	always @(posedge clk) begin
		vrrb_pkg::out_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer %p", out_data);
			end else begin
				e = expected_results.pop_front();
				if (out_data !== e) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p got %p", e, out_data);
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("[variable_record_ring_buffer] ERROR");
			$finish;
		end
	end

	// valid stays up between back-to-back transfers and drops only while idling
	task automatic send_item(vrrb_pkg::in_t c);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_ring(c);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		int unsigned v;
		wait_drain();
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val[vrrb_pkg::RING_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == vrrb_pkg::REG_RING_BYTES) begin
			v = val & 13'h1FFF;
			ring_size = v < 16 ? 16 : v > BUF ? BUF : v;
		end else map_on = val & 1;
		clear_ring();
	endtask

	function automatic vrrb_pkg::in_t make_cmd(vrrb_pkg::cmd_t op, int unsigned len,
			int unsigned b, int unsigned mb, int unsigned mr, logic [31:0] h);
		vrrb_pkg::in_t c;
		c.cmd = op; c.record_length = len[11:0]; c.data_byte = b[7:0];
		c.max_bytes = mb[5:0]; c.max_records = mr[3:0]; c.handle = h;
		return c;
	endfunction

	// one well-formed record push with random content
	task automatic push_record(int unsigned len);
		send_item(make_cmd(vrrb_pkg::CMD_PUSH_BEGIN, len, $urandom, $urandom, $urandom,
			$urandom));
		for (int unsigned i = 0; i < len && push_open; i++)
			send_item(make_cmd(vrrb_pkg::CMD_PUSH_BYTE, $urandom, $urandom, $urandom,
				$urandom, $urandom));
	endtask

	typedef struct {
		vrrb_pkg::in_t     c;
		logic              typed;
		vrrb_pkg::status_t st;
	} row_t;

	initial begin
		row_t rows [$];
		vrrb_pkg::in_t c;
		int unsigned r, len;
		for (int i = 0; i < BUF; i++) ring_mem[i] = '0;
		ring_size = BUF; map_on = 1; next_h = '0;
		clear_ring();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: status typed in for the obvious error rows
		rows.push_back('{make_cmd(vrrb_pkg::CMD_POP, 0, 0, 63, 15, 0), 1,
			vrrb_pkg::ST_UNDERFLOW});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_GET, 0, 0, 63, 0, 32'hFFFF_FFFF), 1,
			vrrb_pkg::ST_BAD_HANDLE});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BYTE, 0, 255, 0, 0, 0), 1,
			vrrb_pkg::ST_OUT_OF_SEQ});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BEGIN, 4095, 0, 0, 0, 0), 1,
			vrrb_pkg::ST_OVERFLOW});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BEGIN, 0, 0, 0, 0, 0), 0,
			vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BEGIN, 3, 0, 0, 0, 0), 0,
			vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_POP, 0, 0, 0, 0, 0), 1,
			vrrb_pkg::ST_OUT_OF_SEQ});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_GET, 0, 0, 8, 0, 0), 1,
			vrrb_pkg::ST_OUT_OF_SEQ});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BEGIN, 1, 0, 0, 0, 0), 1,
			vrrb_pkg::ST_OUT_OF_SEQ});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BYTE, 4095, 8'hFF, 63, 15,
			32'hFFFF_FFFF), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BYTE, 0, 8'h00, 0, 0, 0), 0,
			vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_PUSH_BYTE, 0, 8'hA5, 0, 0, 0), 0,
			vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_GET, 0, 0, 0, 0, 1), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_GET, 0, 0, 2, 0, 1), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_GET, 0, 0, 63, 0, 0), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_POP, 0, 0, 63, 0, 0), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_POP, 0, 0, 2, 15, 0), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_POP, 0, 0, 63, 15, 0), 0, vrrb_pkg::ST_OK});
		rows.push_back('{make_cmd(vrrb_pkg::CMD_POP, 0, 0, 56, 8, 0), 1,
			vrrb_pkg::ST_UNDERFLOW});
		foreach (rows[i]) begin
			send_item(rows[i].c);
			if (rows[i].typed && expected_results[$].status != rows[i].st) begin
				errors++;
				if (errors <= 10)
					$display("row %0d: expected %0d, predictor gives %0d", i, rows[i].st,
						expected_results[$].status);
			end
		end

		write_reg(vrrb_pkg::REG_MAP_ENABLE, 0);
		push_record(2);
		send_item(make_cmd(vrrb_pkg::CMD_GET, 0, 0, 8, 0, 0));
		write_reg(vrrb_pkg::REG_RING_BYTES, 0);
		push_record(8);
		push_record(0);
		send_item(make_cmd(vrrb_pkg::CMD_PUSH_BEGIN, 0, 0, 0, 0, 0));
		send_item(make_cmd(vrrb_pkg::CMD_POP, 0, 0, 63, 15, 0));
		write_reg(vrrb_pkg::REG_MAP_ENABLE, 1);
		write_reg(vrrb_pkg::REG_RING_BYTES, 13'h1FFF);

		// random phases over sizes and idling
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 53; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 53; end
				default: begin send_idle = 37; recv_idle = 37; end
			endcase
			write_reg(vrrb_pkg::REG_RING_BYTES,
				ph == 0 ? 16 : ph == 5 ? 4096 : $urandom_range(16, 200));
			if (ph == 3 || ph == 6) write_reg(vrrb_pkg::REG_MAP_ENABLE, $urandom_range(1));
			for (int k = 0; k < 12; k++) begin
				r = $urandom_range(99);
				if (r < 45) begin
					// the longest record never fits any ring size
					len = ($urandom_range(9) == 0) ? 4095 : $urandom_range(12);
					push_record(len);
				end else if (r < 70)
					send_item(make_cmd(vrrb_pkg::CMD_POP, $urandom, $urandom, $urandom,
						$urandom, $urandom));
				else if (r < 88)
					send_item(make_cmd(vrrb_pkg::CMD_GET, $urandom, $urandom, $urandom,
						$urandom, ($urandom_range(3) == 0) ? $urandom
						: oldest_h + $urandom_range(4)));
				else begin
					c = make_cmd(vrrb_pkg::cmd_t'($urandom_range(3)), $urandom_range(20),
						$urandom, $urandom, $urandom, $urandom);
					send_item(c);
				end
			end
		end
		send_idle = 0; recv_idle = 0;
		wait_drain();
		if (errors == 0) begin
			$display("[variable_record_ring_buffer] OK");
		end else begin
			$display("[variable_record_ring_buffer] ERROR");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
src/vrrb_pkg.sv
src/vrrb_ram.sv
src/vrrb_ctrl.sv
src/variable_record_ring_buffer.sv
tb/sv/testbench.sv
